// ===== hw/rtl/lfce_pkg.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluator package
// Shared item types and operation codes for the condition evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfce_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    KIND_SUB   = 3'd0,
    KIND_LOGIC = 3'd1,
    KIND_ADD   = 3'd2,
    KIND_INC   = 3'd3,
    KIND_DEC   = 3'd4
  } op_kind_t;

  typedef enum logic [2:0] {
    PAIR_O  = 3'd0,
    PAIR_B  = 3'd1,
    PAIR_Z  = 3'd2,
    PAIR_BE = 3'd3,
    PAIR_S  = 3'd4,
    PAIR_P  = 3'd5,
    PAIR_L  = 3'd6,
    PAIR_LE = 3'd7
  } cond_pair_t;

  localparam logic [WordW-1:0] SignBit = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]       cond_code;
    logic [2:0]       op_kind;
    logic [2:0]       op_width;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [WordW-1:0] result_r;
    logic             carry_kept;
  } in_item_t;

  typedef struct packed {
    logic cond_true;
    logic handled;
  } out_item_t;

endpackage

// ===== hw/rtl/lfce_in_if.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluator input channel
// Valid/ready channel carrying one condition query item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfce_in_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               cond_code;
  logic [2:0]               op_kind;
  logic [2:0]               op_width;
  logic [lfce_pkg::WordW-1:0] operand_a;
  logic [lfce_pkg::WordW-1:0] operand_b;
  logic [lfce_pkg::WordW-1:0] result_r;
  logic                     carry_kept;

  modport source (
    output valid, cond_code, op_kind, op_width, operand_a, operand_b, result_r,
           carry_kept,
    input  ready
  );

  modport sink (
    input  valid, cond_code, op_kind, op_width, operand_a, operand_b, result_r,
           carry_kept,
    output ready
  );
endinterface

// ===== hw/rtl/lfce_out_if.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluator result channel
// Valid/ready channel carrying one condition result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfce_out_if;
  logic valid;
  logic ready;
  logic cond_true;
  logic handled;

  modport source (
    output valid, cond_true, handled,
    input  ready
  );

  modport sink (
    input  valid, cond_true, handled,
    output ready
  );
endinterface

// ===== hw/rtl/lfce_eval.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluation logic
// Normalises the recorded operands and derives the requested condition.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfce_eval (
  input  lfce_pkg::in_item_t  item,
  output lfce_pkg::out_item_t res
);

  localparam int unsigned W = lfce_pkg::WordW;

  function automatic logic lt_s(input logic [W-1:0] x, input logic [W-1:0] y);
    return (x ^ lfce_pkg::SignBit) < (y ^ lfce_pkg::SignBit);
  endfunction

  function automatic logic ovf_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                   input logic [W-1:0] z);
    logic [W-1:0] t;
    t = (x ^ y) & (x ^ z);
    return t[W-1];
  endfunction

  logic [4:0]   shift_amt;
  logic [W-1:0] a_n;
  logic [W-1:0] b_n;
  logic [W-1:0] r_n;
  logic [W-1:0] one_n;
  logic [W-1:0] neg_one_n;
  logic [W-1:0] ovf;
  logic         zf;
  logic         sf;
  logic         pf;
  logic         add_cf;
  logic         add_less;
  logic         is_dec;
  logic         base_v;
  logic         known;
  lfce_pkg::cond_pair_t pair;

  always_comb begin
    case (item.op_width)
      3'd1:    shift_amt = 5'd24;
      3'd2:    shift_amt = 5'd16;
      3'd3:    shift_amt = 5'd8;
      default: shift_amt = 5'd0;
    endcase
  end

  assign a_n       = item.operand_a << shift_amt;
  assign b_n       = item.operand_b << shift_amt;
  assign r_n       = item.result_r << shift_amt;
  assign one_n     = {{(W-1){1'b0}}, 1'b1} << shift_amt;
  assign neg_one_n = {W{1'b0}} - one_n;

  assign zf       = (r_n == {W{1'b0}});
  assign sf       = r_n[W-1];
  assign pf       = ~^item.result_r[7:0];
  assign ovf      = (a_n ^ r_n) & (b_n ^ r_n);
  assign add_cf   = r_n < a_n;
  assign add_less = r_n[W-1] ^ ovf[W-1];
  assign is_dec   = (item.op_kind == lfce_pkg::KIND_DEC);
  assign pair     = lfce_pkg::cond_pair_t'(item.cond_code[3:1]);
  assign known    = (item.op_kind <= lfce_pkg::KIND_DEC);

  always_comb begin
    base_v = 1'b0;
    if (pair == lfce_pkg::PAIR_Z) begin
      base_v = zf;
    end else if (pair == lfce_pkg::PAIR_S) begin
      base_v = sf;
    end else if (pair == lfce_pkg::PAIR_P) begin
      base_v = pf;
    end else begin
      case (item.op_kind)
        lfce_pkg::KIND_SUB: begin
          case (pair)
            lfce_pkg::PAIR_O:  base_v = ovf_sub(a_n, b_n, r_n);
            lfce_pkg::PAIR_B:  base_v = a_n < b_n;
            lfce_pkg::PAIR_BE: base_v = a_n <= b_n;
            lfce_pkg::PAIR_L:  base_v = lt_s(a_n, b_n);
            default:           base_v = !lt_s(b_n, a_n);
          endcase
        end
        lfce_pkg::KIND_LOGIC: begin
          case (pair)
            lfce_pkg::PAIR_O:  base_v = 1'b0;
            lfce_pkg::PAIR_B:  base_v = 1'b0;
            lfce_pkg::PAIR_BE: base_v = zf;
            lfce_pkg::PAIR_L:  base_v = sf;
            default:           base_v = zf | sf;
          endcase
        end
        lfce_pkg::KIND_ADD: begin
          case (pair)
            lfce_pkg::PAIR_O:  base_v = ovf[W-1];
            lfce_pkg::PAIR_B:  base_v = add_cf;
            lfce_pkg::PAIR_BE: base_v = add_cf | zf;
            lfce_pkg::PAIR_L:  base_v = add_less;
            default:           base_v = add_less | zf;
          endcase
        end
        default: begin
          case (pair)
            lfce_pkg::PAIR_O:  base_v = (is_dec ? a_n : r_n) == lfce_pkg::SignBit;
            lfce_pkg::PAIR_B:  base_v = item.carry_kept;
            lfce_pkg::PAIR_BE: base_v = item.carry_kept | zf;
            lfce_pkg::PAIR_L:  base_v = is_dec ? !lt_s({W{1'b0}}, a_n)
                                               : lt_s(a_n, neg_one_n);
            default:           base_v = is_dec ? !lt_s(one_n, a_n)
                                               : !lt_s(neg_one_n, a_n);
          endcase
        end
      endcase
    end
  end

  assign res.handled   = known;
  assign res.cond_true = known & (base_v ^ item.cond_code[0]);

endmodule

// ===== hw/rtl/lazy_flags_condition_eval_top.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluator
// Decides an x86 condition code from a record of the last flag operation.
// ----------------------------------------------------------------------------
// The block accepts one item in every cycle. An accepted item is captured in
// an input register, evaluated by the normalising shift and the parallel
// compares, and its result is held in an output register, from which it is
// presented. A waiting result holds the output register; the input register
// still takes one more item, and the input stalls only while both registers
// are full.
`timescale 1ns / 1ps

module lazy_flags_condition_eval_top (
  input  logic          clk,
  input  logic          rst_n,
  lfce_in_if.sink       in_ch,
  lfce_out_if.source    out_ch
);

  logic                in_vld_r;
  logic                in_vld_nxt;
  lfce_pkg::in_item_t  in_item_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  lfce_pkg::out_item_t out_item_r;
  lfce_pkg::out_item_t eval_res;
  logic                out_adv;
  logic                in_take;

  assign out_adv = !out_vld_r || out_ch.ready;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_vld_r || out_adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.ready) begin
      in_vld_nxt = in_ch.valid;
    end
    out_vld_nxt = out_vld_r;
    if (out_adv) begin
      out_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.cond_code  <= in_ch.cond_code;
      in_item_r.op_kind    <= in_ch.op_kind;
      in_item_r.op_width   <= in_ch.op_width;
      in_item_r.operand_a  <= in_ch.operand_a;
      in_item_r.operand_b  <= in_ch.operand_b;
      in_item_r.result_r   <= in_ch.result_r;
      in_item_r.carry_kept <= in_ch.carry_kept;
    end
    if (out_adv && in_vld_r) begin
      out_item_r <= eval_res;
    end
  end

  lfce_eval u_eval (
    .item (in_item_r),
    .res  (eval_res)
  );

  assign out_ch.valid     = out_vld_r;
  assign out_ch.cond_true = out_item_r.cond_true;
  assign out_ch.handled   = out_item_r.handled;

endmodule

// ===== tb/sv/lazy_flags_condition_eval_top_tb.sv =====
// ----------------------------------------------------------------------------
// Lazy flags condition evaluator testbench
// Sends condition queries through the valid/ready input channel, stalls both
// sides at random and checks every result item against an independent
// evaluation of the condition from the recorded flag operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lazy_flags_condition_eval_top_tb;

  typedef enum logic [3:0] {
    CC_O  = 4'd0,
    CC_NO = 4'd1,
    CC_B  = 4'd2,
    CC_NB = 4'd3,
    CC_Z  = 4'd4,
    CC_NZ = 4'd5,
    CC_BE = 4'd6,
    CC_A  = 4'd7,
    CC_S  = 4'd8,
    CC_NS = 4'd9,
    CC_P  = 4'd10,
    CC_NP = 4'd11,
    CC_L  = 4'd12,
    CC_GE = 4'd13,
    CC_LE = 4'd14,
    CC_G  = 4'd15
  } cond_code_t;

  localparam logic [2:0] KindSpareA = 3'd5;
  localparam logic [2:0] KindSpareB = 3'd6;
  localparam logic [2:0] KindSpareC = 3'd7;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SPARSE
  } idle_mode_t;

  class condition_scoreboard;
    lfce_pkg::out_item_t verdict_q[$];
    int unsigned         errors;

    function new();
      errors = 0;
    endfunction

    function lfce_pkg::out_item_t evaluate(lfce_pkg::in_item_t q);
      int unsigned shamt;
      logic [31:0] a, b, r, one, neg_one, ovf;
      logic        zf, sf, parity, flag_o, flag_b, flag_be, flag_l, flag_le, v;
      lfce_pkg::out_item_t res;
      res = '0;
      if (q.op_kind > lfce_pkg::KIND_DEC) return res;
      shamt   = (q.op_width >= 3'd1 && q.op_width <= 3'd3) ? 32 - 8 * q.op_width : 0;
      a       = q.operand_a << shamt;
      b       = q.operand_b << shamt;
      r       = q.result_r << shamt;
      one     = 32'd1 << shamt;
      neg_one = -one;
      zf      = (r == '0);
      sf      = r[31];
      parity  = ~^q.result_r[7:0];
      flag_o  = 1'b0;
      flag_b  = 1'b0;
      flag_be = 1'b0;
      flag_l  = 1'b0;
      flag_le = 1'b0;
      case (q.op_kind)
        lfce_pkg::KIND_SUB: begin
          ovf     = (a ^ b) & (a ^ r);
          flag_o  = ovf[31];
          flag_b  = a < b;
          flag_be = a <= b;
          flag_l  = $signed(a) < $signed(b);
          flag_le = $signed(a) <= $signed(b);
        end
        lfce_pkg::KIND_LOGIC: begin
          flag_be = zf;
          flag_l  = sf;
          flag_le = zf | sf;
        end
        lfce_pkg::KIND_ADD: begin
          ovf     = (a ^ r) & (b ^ r);
          flag_o  = ovf[31];
          flag_b  = r < a;
          flag_be = (r < a) | zf;
          ovf     = r ^ ovf;
          flag_l  = ovf[31];
          flag_le = ovf[31] | zf;
        end
        lfce_pkg::KIND_INC: begin
          flag_o  = (r == lfce_pkg::SignBit);
          flag_b  = q.carry_kept;
          flag_be = q.carry_kept | zf;
          flag_l  = $signed(a) < $signed(neg_one);
          flag_le = $signed(a) <= $signed(neg_one);
        end
        default: begin
          flag_o  = (a == lfce_pkg::SignBit);
          flag_b  = q.carry_kept;
          flag_be = q.carry_kept | zf;
          flag_l  = $signed(a) <= 0;
          flag_le = $signed(a) <= $signed(one);
        end
      endcase
      case (lfce_pkg::cond_pair_t'(q.cond_code[3:1]))
        lfce_pkg::PAIR_O:  v = flag_o;
        lfce_pkg::PAIR_B:  v = flag_b;
        lfce_pkg::PAIR_Z:  v = zf;
        lfce_pkg::PAIR_BE: v = flag_be;
        lfce_pkg::PAIR_S:  v = sf;
        lfce_pkg::PAIR_P:  v = parity;
        lfce_pkg::PAIR_L:  v = flag_l;
        default:           v = flag_le;
      endcase
      res.cond_true = v ^ q.cond_code[0];
      res.handled   = 1'b1;
      return res;
    endfunction

    function void note_query(lfce_pkg::in_item_t q);
      verdict_q.push_back(evaluate(q));
    endfunction

    function void check_result(lfce_pkg::out_item_t got);
      lfce_pkg::out_item_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got cond_true %0b handled %0b",
                 $time, got.cond_true, got.handled);
        return;
      end
      want = verdict_q.pop_front();
      if (got.cond_true !== want.cond_true) begin
        errors++;
        $display("%0t: cond_true expected %0b, got %0b", $time, want.cond_true,
                 got.cond_true);
      end
      if (got.handled !== want.handled) begin
        errors++;
        $display("%0t: handled expected %0b, got %0b", $time, want.handled, got.handled);
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lfce_in_if  in_ch ();
  lfce_out_if out_ch ();

  lazy_flags_condition_eval_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  condition_scoreboard board = new();
  idle_mode_t          tx_mode = IDLE_NONE;
  idle_mode_t          rx_mode = IDLE_NONE;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned draw_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_word(input logic [2:0] width);
    int unsigned bits;
    logic [31:0] span, word;
    bits = (width >= 3'd1 && width <= 3'd3) ? 8 * width : 32;
    span = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = span;
      2:       word = 32'd1 << (bits - 1);
      3:       word = span >> 1;
      4:       word = 32'd1;
      default: word = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1) word = (word & span) | ($urandom & ~span);
    return word;
  endfunction

  function automatic lfce_pkg::in_item_t random_query();
    lfce_pkg::in_item_t q;
    q.cond_code = 4'($urandom_range(0, 15));
    q.op_kind   = ($urandom_range(0, 9) == 0)
                  ? 3'($urandom_range(KindSpareA, KindSpareC))
                  : 3'($urandom_range(lfce_pkg::KIND_SUB, lfce_pkg::KIND_DEC));
    q.op_width  = 3'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                : $urandom_range(0, 7));
    q.operand_a = pick_word(q.op_width);
    q.operand_b = ($urandom_range(0, 7) == 0) ? q.operand_a : pick_word(q.op_width);
    q.result_r  = pick_word(q.op_width);
    q.carry_kept = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      case (q.op_kind)
        lfce_pkg::KIND_SUB: q.result_r = q.operand_a - q.operand_b;
        lfce_pkg::KIND_LOGIC: begin
          case ($urandom_range(0, 2))
            0:       q.result_r = q.operand_a & q.operand_b;
            1:       q.result_r = q.operand_a | q.operand_b;
            default: q.result_r = q.operand_a ^ q.operand_b;
          endcase
        end
        lfce_pkg::KIND_ADD: q.result_r = q.operand_a + q.operand_b;
        lfce_pkg::KIND_INC: q.result_r = q.operand_a + 32'd1;
        lfce_pkg::KIND_DEC: q.result_r = q.operand_a - 32'd1;
        default:            q.result_r = pick_word(q.op_width);
      endcase
    end
    return q;
  endfunction

  task automatic send_query(input lfce_pkg::in_item_t q);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.cond_code  <= q.cond_code;
    in_ch.op_kind    <= q.op_kind;
    in_ch.op_width   <= q.op_width;
    in_ch.operand_a  <= q.operand_a;
    in_ch.operand_b  <= q.operand_b;
    in_ch.result_r   <= q.result_r;
    in_ch.carry_kept <= q.carry_kept;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_query(q);
  endtask

  task automatic send_fields(input cond_code_t cc, input logic [2:0] kind,
                             input logic [2:0] width, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] r,
                             input logic carry);
    lfce_pkg::in_item_t q;
    q.cond_code  = cc;
    q.op_kind    = kind;
    q.op_width   = width;
    q.operand_a  = a;
    q.operand_b  = b;
    q.result_r   = r;
    q.carry_kept = carry;
    send_query(q);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    lfce_pkg::out_item_t got;
    int unsigned hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_gap(rx_mode);
      repeat (hold) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.cond_true = out_ch.cond_true;
      got.handled   = out_ch.handled;
      board.check_result(got);
    end
  end

  initial begin
    idle_mode_t tx_plan[7];
    idle_mode_t rx_plan[7];
    tx_plan = '{IDLE_NONE, IDLE_FULL, IDLE_SPARSE, IDLE_NONE, IDLE_FULL,
                IDLE_SPARSE, IDLE_NONE};
    rx_plan = '{IDLE_NONE, IDLE_FULL, IDLE_SPARSE, IDLE_FULL, IDLE_NONE,
                IDLE_NONE, IDLE_SPARSE};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cond_code  = '0;
    in_ch.op_kind    = '0;
    in_ch.op_width   = '0;
    in_ch.operand_a  = '0;
    in_ch.operand_b  = '0;
    in_ch.result_r   = '0;
    in_ch.carry_kept = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_mode = IDLE_SPARSE;
    rx_mode = IDLE_SPARSE;
    send_fields(CC_O,  lfce_pkg::KIND_SUB,   3'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                lfce_pkg::SignBit, 1'b0);
    send_fields(CC_NO, lfce_pkg::KIND_SUB,   3'd1, 32'h0000_0080, 32'h0000_0001, 32'h7F,
                1'b0);
    send_fields(CC_B,  lfce_pkg::KIND_SUB,   3'd2, 32'h0000_0000, 32'h0000_FFFF, 32'h1,
                1'b0);
    send_fields(CC_NB, lfce_pkg::KIND_SUB,   3'd3, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0,
                1'b1);
    send_fields(CC_Z,  lfce_pkg::KIND_LOGIC, 3'd4, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_fields(CC_NZ, lfce_pkg::KIND_LOGIC, 3'd1, 32'hFFFF_FF00, 32'hFF, 32'hFFFF_FF00,
                1'b0);
    send_fields(CC_BE, lfce_pkg::KIND_ADD,   3'd4, 32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0);
    send_fields(CC_A,  lfce_pkg::KIND_ADD,   3'd2, 32'h0000_7FFF, 32'h1, 32'h8000, 1'b0);
    send_fields(CC_S,  lfce_pkg::KIND_INC,   3'd1, 32'h0000_007F, 32'h0, 32'h80, 1'b1);
    send_fields(CC_NS, lfce_pkg::KIND_DEC,   3'd3, 32'h0080_0000, 32'h0, 32'h7F_FFFF, 1'b0);
    send_fields(CC_P,  lfce_pkg::KIND_SUB,   3'd4, 32'h3, 32'h0, 32'h3, 1'b0);
    send_fields(CC_NP, lfce_pkg::KIND_ADD,   3'd2, 32'h100, 32'h0, 32'h100, 1'b0);
    send_fields(CC_L,  lfce_pkg::KIND_DEC,   3'd4, lfce_pkg::SignBit, 32'h0, 32'h7FFF_FFFF,
                1'b0);
    send_fields(CC_GE, lfce_pkg::KIND_INC,   3'd4, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
    send_fields(CC_LE, lfce_pkg::KIND_DEC,   3'd1, 32'h1, 32'h0, 32'h0, 1'b0);
    send_fields(CC_G,  lfce_pkg::KIND_INC,   3'd3, 32'hFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_fields(CC_O,  lfce_pkg::KIND_INC,   3'd4, 32'h7FFF_FFFF, 32'h0, lfce_pkg::SignBit,
                1'b0);
    send_fields(CC_O,  lfce_pkg::KIND_DEC,   3'd4, lfce_pkg::SignBit, 32'h0, 32'h7FFF_FFFF,
                1'b0);
    send_fields(CC_B,  lfce_pkg::KIND_INC,   3'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
    send_fields(CC_L,  lfce_pkg::KIND_LOGIC, 3'd4, 32'h0, 32'h0, lfce_pkg::SignBit, 1'b0);
    send_fields(CC_G,  lfce_pkg::KIND_SUB,   3'd0, lfce_pkg::SignBit, 32'h7FFF_FFFF, 32'h1,
                1'b0);
    send_fields(CC_BE, lfce_pkg::KIND_SUB,   3'd5, 32'h1, 32'h2, 32'hFFFF_FFFF, 1'b1);
    send_fields(CC_Z,  KindSpareA, 3'd4, 32'h0, 32'h0, 32'h0, 1'b0);
    send_fields(CC_G,  KindSpareB, 3'd1, 32'hFFFF_FFFF, 32'h1, 32'h0, 1'b1);
    send_fields(CC_L,  KindSpareC, 3'd7, lfce_pkg::SignBit, 32'hFFFF_FFFF, 32'h5, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      tx_mode = tx_plan[phase];
      rx_mode = rx_plan[phase];
      repeat (150) send_query(random_query());
      wait_drained();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lfce_pkg.sv
hw/rtl/lfce_in_if.sv
hw/rtl/lfce_out_if.sv
hw/rtl/lfce_eval.sv
hw/rtl/lazy_flags_condition_eval_top.sv
tb/sv/lazy_flags_condition_eval_top_tb.sv
